@@ rtl/core/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, character constants and helper functions of the integer to
// text converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

	localparam int RADIX_BITS = 6;
	localparam int CHAR_BITS  = 7;

	localparam logic [CHAR_BITS-1:0]  CH_ZERO   = 7'd48;
	localparam logic [CHAR_BITS-1:0]  CH_ALPHA  = 7'd65;
	localparam logic [CHAR_BITS-1:0]  CH_MINUS  = 7'd45;
	localparam logic [RADIX_BITS-1:0] DEC_RADIX = 6'd10;
	localparam logic [RADIX_BITS-1:0] MIN_RADIX = 6'd2;
	localparam logic [RADIX_BITS-1:0] MAX_RADIX = 6'd36;

	typedef logic [RADIX_BITS-1:0] radix_t;
	typedef logic [CHAR_BITS-1:0]  char_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic load;      // take a new word and radix
		logic step;      // one restoring division step
		logic wr_digit;  // store the finished digit, restart the remainder
		logic wr_sign;   // store a minus sign
		logic rd_en;     // read the text buffer at the read index
		logic rd_dec;    // move the read index toward the first digit
	} itoa_cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic q_zero;    // quotient is zero, no more digits
		logic neg;       // the word was a negative decimal value
		logic last;      // read index points at the final character
	} itoa_sts_t;

	function automatic radix_t clamp_radix(input radix_t r);
		radix_t res;
		res = r;
		if (r < MIN_RADIX) begin
			res = MIN_RADIX;
		end else if (r > MAX_RADIX) begin
			res = MAX_RADIX;
		end
		return res;
	endfunction

	function automatic char_t digit_char(input radix_t d);
		char_t wide;
		wide = {1'b0, d};
		if (d > 6'd9) begin
			return char_t'(wide + CH_ALPHA - 7'd10);
		end
		return char_t'(wide + CH_ZERO);
	endfunction

endpackage

@@ rtl/core/itoa_if.sv @@
// ----------------------------------------------------------------------------
// itoa_if
// Valid/ready channels of the converter: the number input and the character
// output.
// ----------------------------------------------------------------------------
interface itoa_in_if #(
	parameter int WORD_BITS = 32
);
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] number_word;
	logic [5:0]           radix;

	modport source (output valid, output number_word, output radix, input ready);
	modport sink   (input valid, input number_word, input radix, output ready);
endinterface

interface itoa_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

@@ rtl/core/itoa_datapath.sv @@
// ----------------------------------------------------------------------------
// itoa_datapath
// Restoring divider by the radix, one quotient bit per cycle, and a text
// buffer that collects the characters least significant first.
// ----------------------------------------------------------------------------
module itoa_datapath #(
	parameter int WORD_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  itoa_pkg::itoa_cmd_t     cmd,
	output itoa_pkg::itoa_sts_t     sts,
	input  logic [WORD_BITS-1:0]    number_word,
	input  logic [5:0]              radix,
	output logic [6:0]              char_code,
	output logic                    last_char
);
	import itoa_pkg::*;

	localparam int TEXT_MAX = WORD_BITS + 1;
	localparam int IDX_W    = $clog2(TEXT_MAX);
	localparam int CNT_W    = $clog2(TEXT_MAX + 1);

	logic [WORD_BITS-1:0] q_q;
	radix_t               r_q;
	radix_t               radix_q;
	logic                 neg_q;
	logic [CNT_W-1:0]     wr_idx_q;
	logic [IDX_W-1:0]     rd_idx_q;
	char_t                rd_data_q;
	char_t                text_mem [TEXT_MAX];

	radix_t               radix_c;
	logic                 neg_c;
	logic [RADIX_BITS:0]  trial;
	logic [RADIX_BITS:0]  diff;
	logic                 ge;
	char_t                wr_data;

	assign radix_c = clamp_radix(radix);
	assign neg_c   = (radix_c == DEC_RADIX) && number_word[WORD_BITS-1];
	assign trial   = {r_q, q_q[WORD_BITS-1]};
	assign diff    = trial - {1'b0, radix_q};
	assign ge      = trial >= {1'b0, radix_q};
	assign wr_data = cmd.wr_sign ? CH_MINUS : digit_char(r_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			radix_q  <= radix_c;
			neg_q    <= neg_c;
			q_q      <= neg_c ? (~number_word + 1'b1) : number_word;
			r_q      <= '0;
			wr_idx_q <= '0;
		end else if (cmd.step) begin
			r_q <= ge ? diff[RADIX_BITS-1:0] : trial[RADIX_BITS-1:0];
			q_q <= {q_q[WORD_BITS-2:0], ge};
		end else if (cmd.wr_digit || cmd.wr_sign) begin
			r_q      <= '0;
			wr_idx_q <= wr_idx_q + 1'b1;
		end

		if (cmd.wr_digit || cmd.wr_sign) begin
			text_mem[wr_idx_q[IDX_W-1:0]] <= wr_data;
			rd_idx_q                      <= wr_idx_q[IDX_W-1:0];
		end else if (cmd.rd_dec) begin
			rd_idx_q <= rd_idx_q - 1'b1;
		end

		if (cmd.rd_en) begin
			rd_data_q <= text_mem[rd_idx_q];
		end
	end

	assign sts.q_zero = (q_q == '0);
	assign sts.neg    = neg_q;
	assign sts.last   = (rd_idx_q == '0);

	assign char_code = rd_data_q;
	assign last_char = sts.last;

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (r_q < radix_q))
		else $error("remainder not below radix during division");

	a_buffer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_digit || cmd.wr_sign) |-> (wr_idx_q < CNT_W'(TEXT_MAX)))
		else $error("text buffer overrun");

	a_read_written: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> ({1'b0, rd_idx_q} < {1'b0, wr_idx_q}))
		else $error("read of a text entry not written for this item");

endmodule

@@ rtl/core/itoa_ctrl.sv @@
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: accepts a word, runs the divider once per digit, adds a sign
// if negative, then plays the text back most significant character first.
// ----------------------------------------------------------------------------
module itoa_ctrl #(
	parameter int WORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output itoa_pkg::itoa_cmd_t cmd,
	input  itoa_pkg::itoa_sts_t sts
);
	import itoa_pkg::*;

	localparam int BIT_W = $clog2(WORD_BITS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_WRITE = 3'd2;
	localparam logic [2:0] S_SIGN  = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [BIT_W-1:0] bit_cnt_q;
	logic [BIT_W-1:0] bit_cnt_d;

	always_comb begin
		state_d   = state_q;
		bit_cnt_d = bit_cnt_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					bit_cnt_d = BIT_W'(WORD_BITS - 1);
					state_d   = S_DIV;
				end
			end
			S_DIV: begin
				cmd.step = 1'b1;
				if (bit_cnt_q == '0) begin
					state_d = S_WRITE;
				end else begin
					bit_cnt_d = bit_cnt_q - 1'b1;
				end
			end
			S_WRITE: begin
				cmd.wr_digit = 1'b1;
				if (!sts.q_zero) begin
					bit_cnt_d = BIT_W'(WORD_BITS - 1);
					state_d   = S_DIV;
				end else if (sts.neg) begin
					state_d = S_SIGN;
				end else begin
					state_d = S_READ;
				end
			end
			S_SIGN: begin
				cmd.wr_sign = 1'b1;
				state_d     = S_READ;
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.last) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_dec = 1'b1;
						state_d    = S_READ;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bit_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			bit_cnt_q <= bit_cnt_d;
		end
	end

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a character is pending");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> ($past(state_q) == S_DIV && $past(bit_cnt_q) == '0))
		else $error("digit stored before the division finished");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && sts.last) |=> in_ready)
		else $error("sequencer did not return to idle after the final character");

endmodule

@@ rtl/core/integer_to_text_any_base_top.sv @@
// ----------------------------------------------------------------------------
// integer_to_text_any_base_top
// Converts a word to ASCII text in any radix from 2 to 36, one character per
// output item, most significant first, with a flag on the final character.
// ----------------------------------------------------------------------------
// Sequence: after the input is taken, every digit runs a full division
//   and a buffer write, then the minus sign is written if there is one.
// A new item is taken only after the final character is accepted, and
//   the divider retires one quotient bit per cycle while it divides.
// Reset: arst_n clears the sequencer to idle; the datapath holds no state
//   that reset needs to clear.
module integer_to_text_any_base_top #(
	parameter int WORD_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	itoa_in_if.sink   in_ch,
	itoa_out_if.source out_ch
);
	import itoa_pkg::*;

	// Command and status between the sequencer and the datapath.
	itoa_cmd_t cmd;
	itoa_sts_t sts;

	// The sequencer owns both handshakes. It takes a new item only when idle,
	// and shows a character only after its registered buffer read is done.
	itoa_ctrl #(
		.WORD_BITS (WORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath divides the magnitude by the radix repeatedly. Each
	// remainder becomes a character in the text buffer, least significant
	// first, and playback walks the buffer backward so the output comes out
	// most significant first. A zero word still runs one division and so
	// produces the single character '0'.
	itoa_datapath #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.number_word (in_ch.number_word),
		.radix       (in_ch.radix),
		.char_code   (out_ch.char_code),
		.last_char   (out_ch.last_char)
	);

endmodule
